// ----- src/mm3_pkg.sv -----
// ============================================================================
// mm3_pkg
// Shared types, codes and constants of the streaming 128-bit block hash.
// ============================================================================
package mm3_pkg;

    localparam logic [63:0] H1_INIT = 64'h9368e53c2f6af274;
    localparam logic [63:0] H2_INIT = 64'h586dcd208f7cd3fd;
    localparam logic [63:0] C1_INIT = 64'h87c37b91114253d5;
    localparam logic [63:0] C2_INIT = 64'h4cf5ad432745937f;
    localparam logic [63:0] H1_ADD  = 64'h0000000052dce729;
    localparam logic [63:0] H2_ADD  = 64'h0000000038495ab5;
    localparam logic [63:0] C1_ADD  = 64'h000000007b7d159c;
    localparam logic [63:0] C2_ADD  = 64'h000000006bce6396;
    localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    // Multiply operation sequence.
    localparam logic [2:0] OP_A_C1  = 3'd0;
    localparam logic [2:0] OP_A_C2  = 3'd1;
    localparam logic [2:0] OP_B_C2  = 3'd2;
    localparam logic [2:0] OP_B_C1  = 3'd3;
    localparam logic [2:0] OP_H1_M1 = 3'd4;
    localparam logic [2:0] OP_H1_M2 = 3'd5;
    localparam logic [2:0] OP_H2_M1 = 3'd6;
    localparam logic [2:0] OP_H2_M2 = 3'd7;

    localparam logic [1:0] X_A  = 2'd0;
    localparam logic [1:0] X_B  = 2'd1;
    localparam logic [1:0] X_H1 = 2'd2;
    localparam logic [1:0] X_H2 = 2'd3;

    localparam logic [1:0] Y_C1 = 2'd0;
    localparam logic [1:0] Y_C2 = 2'd1;
    localparam logic [1:0] Y_M1 = 2'd2;
    localparam logic [1:0] Y_M2 = 2'd3;

    localparam logic [2:0] WB_A_ROT = 3'd0;
    localparam logic [2:0] WB_B_ROT = 3'd1;
    localparam logic [2:0] WB_MIX1  = 3'd2;
    localparam logic [2:0] WB_MIX2  = 3'd3;
    localparam logic [2:0] WB_H1    = 3'd4;
    localparam logic [2:0] WB_H2    = 3'd5;

    typedef struct packed {
        logic [1:0] x_sel;
        logic [1:0] y_sel;
        logic       pre_xs;
        logic [2:0] wb;
    } mop_t;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic [2:0] op;
        logic       mul_wb;
        logic       post;
        logic       fin0;
        logic       fin1;
        logic       fx;
        logic       fout;
    } mm3_cmd_t;

    function automatic mop_t mop_lookup(input logic [2:0] op);
        mop_t m;
        case (op)
            OP_A_C1:  m = '{x_sel: X_A,  y_sel: Y_C1, pre_xs: 1'b0, wb: WB_A_ROT};
            OP_A_C2:  m = '{x_sel: X_A,  y_sel: Y_C2, pre_xs: 1'b0, wb: WB_MIX1};
            OP_B_C2:  m = '{x_sel: X_B,  y_sel: Y_C2, pre_xs: 1'b0, wb: WB_B_ROT};
            OP_B_C1:  m = '{x_sel: X_B,  y_sel: Y_C1, pre_xs: 1'b0, wb: WB_MIX2};
            OP_H1_M1: m = '{x_sel: X_H1, y_sel: Y_M1, pre_xs: 1'b1, wb: WB_H1};
            OP_H1_M2: m = '{x_sel: X_H1, y_sel: Y_M2, pre_xs: 1'b1, wb: WB_H1};
            OP_H2_M1: m = '{x_sel: X_H2, y_sel: Y_M1, pre_xs: 1'b1, wb: WB_H2};
            OP_H2_M2: m = '{x_sel: X_H2, y_sel: Y_M2, pre_xs: 1'b1, wb: WB_H2};
            default:  m = '{x_sel: X_A,  y_sel: Y_C1, pre_xs: 1'b0, wb: WB_A_ROT};
        endcase
        return m;
    endfunction

    function automatic logic [63:0] xs33(input logic [63:0] k);
        return k ^ (k >> 33);
    endfunction

    function automatic logic [63:0] rotl23(input logic [63:0] x);
        return {x[40:0], x[63:41]};
    endfunction

    function automatic logic [63:0] rotl41(input logic [63:0] x);
        return {x[22:0], x[63:23]};
    endfunction

endpackage

// ----- src/mm3_blk_if.sv -----
// ============================================================================
// mm3_blk_if
// Block channel: two message words, a valid byte count and a last mark.
// ============================================================================
interface mm3_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_low;
    logic [63:0] word_high;
    logic [4:0]  valid_bytes;
    logic        last_block;

    modport source (
        output valid,
        output word_low,
        output word_high,
        output valid_bytes,
        output last_block,
        input  ready
    );

    modport sink (
        input  valid,
        input  word_low,
        input  word_high,
        input  valid_bytes,
        input  last_block,
        output ready
    );
endinterface

// ----- src/mm3_hash_if.sv -----
// ============================================================================
// mm3_hash_if
// Result channel: the two 64-bit halves of the finished hash.
// ============================================================================
interface mm3_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_lo;
    logic [63:0] hash_hi;

    modport source (
        output valid,
        output hash_lo,
        output hash_hi,
        input  ready
    );

    modport sink (
        input  valid,
        input  hash_lo,
        input  hash_hi,
        output ready
    );
endinterface

// ----- src/mm3_mul.sv -----
// ============================================================================
// mm3_mul
// Iterative 64x64 multiplier keeping the low 64 product bits, built from one
// 32x32 multiplier used in turn for the low-low, low-high and high-low products.
// ============================================================================
module mm3_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x,
    input  logic [63:0] y,
    output logic        done,
    output logic [63:0] p
);

    localparam logic [1:0] ST_LL = 2'd0;
    localparam logic [1:0] ST_LH = 2'd1;
    localparam logic [1:0] ST_HL = 2'd2;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [1:0]  step_reg, step_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] ma, mb;
    logic [63:0] prod;

    always_comb
    begin
        case (step_reg)
            ST_LL:   begin ma = x_reg[31:0];  mb = y_reg[31:0];  end
            ST_LH:   begin ma = x_reg[31:0];  mb = y_reg[63:32]; end
            ST_HL:   begin ma = x_reg[63:32]; mb = y_reg[31:0];  end
            default: begin ma = x_reg[31:0];  mb = y_reg[31:0];  end
        endcase
        prod = 64'(ma) * 64'(mb);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = ST_LL;
            x_next    = x;
            y_next    = y;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                ST_LL:
                begin
                    lo_next   = prod;
                    step_next = ST_LH;
                end
                ST_LH:
                begin
                    hi_next   = lo_reg[63:32] + prod[31:0];
                    step_next = ST_HL;
                end
                default:
                begin
                    hi_next   = hi_reg + prod[31:0];
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    step_next = ST_LL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= ST_LL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign done = done_reg;
    assign p    = {hi_reg, lo_reg[31:0]};

endmodule

// ----- src/mm3_datapath.sv -----
// ============================================================================
// mm3_datapath
// Hash state, seed, operand registers, shared multiplier and result register.
// ============================================================================
module mm3_datapath #(
    parameter int LENGTH_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mm3_pkg::mm3_cmd_t  cmd,
    output logic               mul_done,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic [63:0]        word_low,
    input  logic [63:0]        word_high,
    input  logic [4:0]         valid_bytes,
    input  logic               last_block,
    output logic [63:0]        hash_lo,
    output logic [63:0]        hash_hi
);

    logic [31:0]            seed_reg, seed_next;
    logic                   fresh_reg, fresh_next;
    logic [63:0]            h1_reg, h1_next;
    logic [63:0]            h2_reg, h2_next;
    logic [63:0]            c1_reg, c1_next;
    logic [63:0]            c2_reg, c2_next;
    logic [LENGTH_BITS-1:0] total_reg, total_next;
    logic [63:0]            a_reg, a_next;
    logic [63:0]            b_reg, b_next;
    logic [4:0]             inc_reg, inc_next;
    logic [63:0]            out_lo_reg, out_lo_next;
    logic [63:0]            out_hi_reg, out_hi_next;

    logic [4:0]     n_sat;
    logic [63:0]    a_in, b_in;
    mm3_pkg::mop_t  mop;
    logic [63:0]    x_raw, mul_x, mul_y, mul_p;
    logic [63:0]    h2x, h1s, h2s;

    assign n_sat = (valid_bytes > mm3_pkg::BLOCK_BYTES) ? mm3_pkg::BLOCK_BYTES : valid_bytes;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            a_in[8*i +: 8] = (!last_block || (5'(i) < n_sat)) ? word_low[8*i +: 8] : 8'h00;
            b_in[8*i +: 8] = (!last_block || (5'(i + 8) < n_sat)) ? word_high[8*i +: 8] : 8'h00;
        end
    end

    assign mop = mm3_pkg::mop_lookup(cmd.op);

    always_comb
    begin
        case (mop.x_sel)
            mm3_pkg::X_A:  x_raw = a_reg;
            mm3_pkg::X_B:  x_raw = b_reg;
            mm3_pkg::X_H1: x_raw = h1_reg;
            default:       x_raw = h2_reg;
        endcase
        mul_x = mop.pre_xs ? mm3_pkg::xs33(x_raw) : x_raw;
        case (mop.y_sel)
            mm3_pkg::Y_C1: mul_y = c1_reg;
            mm3_pkg::Y_C2: mul_y = c2_reg;
            mm3_pkg::Y_M1: mul_y = mm3_pkg::FMIX_M1;
            default:       mul_y = mm3_pkg::FMIX_M2;
        endcase
    end

    mm3_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign h2x = h2_reg ^ 64'(total_reg);
    assign h1s = mm3_pkg::xs33(h1_reg);
    assign h2s = mm3_pkg::xs33(h2_reg);

    always_comb
    begin
        seed_next   = seed_reg;
        fresh_next  = fresh_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        c1_next     = c1_reg;
        c2_next     = c2_reg;
        total_next  = total_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        inc_next    = inc_reg;
        out_lo_next = out_lo_reg;
        out_hi_next = out_hi_reg;

        if (cmd.load)
        begin
            a_next     = a_in;
            b_next     = b_in;
            inc_next   = last_block ? n_sat : mm3_pkg::BLOCK_BYTES;
            fresh_next = 1'b0;
        end

        if (cmd.mul_wb)
        begin
            case (mop.wb)
                mm3_pkg::WB_A_ROT: a_next = mm3_pkg::rotl23(mul_p);
                mm3_pkg::WB_B_ROT: b_next = mm3_pkg::rotl23(mul_p);
                mm3_pkg::WB_MIX1:
                begin
                    h1_next = (h1_reg ^ mul_p) + h2_reg;
                    h2_next = mm3_pkg::rotl41(h2_reg);
                end
                mm3_pkg::WB_MIX2:  h2_next = (h2_reg ^ mul_p) + h1_reg;
                mm3_pkg::WB_H1:    h1_next = mul_p;
                default:           h2_next = mul_p;
            endcase
        end

        if (cmd.post)
        begin
            h1_next    = (h1_reg << 1) + h1_reg + mm3_pkg::H1_ADD;
            h2_next    = (h2_reg << 1) + h2_reg + mm3_pkg::H2_ADD;
            c1_next    = (c1_reg << 2) + c1_reg + mm3_pkg::C1_ADD;
            c2_next    = (c2_reg << 2) + c2_reg + mm3_pkg::C2_ADD;
            total_next = total_reg + LENGTH_BITS'(inc_reg);
        end

        if (cmd.fin0)
        begin
            h1_next = h1_reg + h2x;
            h2_next = h2x;
        end

        if (cmd.fin1)
        begin
            h2_next = h2_reg + h1_reg;
        end

        if (cmd.fx)
        begin
            h1_next = h1s + h2s;
            h2_next = h2s;
        end

        if (cmd.fout)
        begin
            out_lo_next = h1_reg;
            out_hi_next = h2_reg + h1_reg;
            h1_next     = mm3_pkg::H1_INIT ^ 64'(seed_reg);
            h2_next     = mm3_pkg::H2_INIT ^ 64'(seed_reg);
            c1_next     = mm3_pkg::C1_INIT;
            c2_next     = mm3_pkg::C2_INIT;
            total_next  = '0;
            fresh_next  = 1'b1;
        end

        if (cfg_we)
        begin
            seed_next = cfg_wdata;
            if (fresh_reg)
            begin
                h1_next = mm3_pkg::H1_INIT ^ 64'(cfg_wdata);
                h2_next = mm3_pkg::H2_INIT ^ 64'(cfg_wdata);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            fresh_reg <= 1'b1;
            h1_reg    <= mm3_pkg::H1_INIT;
            h2_reg    <= mm3_pkg::H2_INIT;
            c1_reg    <= mm3_pkg::C1_INIT;
            c2_reg    <= mm3_pkg::C2_INIT;
            total_reg <= '0;
        end
        else
        begin
            seed_reg  <= seed_next;
            fresh_reg <= fresh_next;
            h1_reg    <= h1_next;
            h2_reg    <= h2_next;
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        inc_reg    <= inc_next;
        out_lo_reg <= out_lo_next;
        out_hi_reg <= out_hi_next;
    end

    assign hash_lo = out_lo_reg;
    assign hash_hi = out_hi_reg;

endmodule

// ----- src/mm3_ctrl.sv -----
// ============================================================================
// mm3_ctrl
// Sequencer for block mixing and finalization, and the output valid flag.
// ============================================================================
module mm3_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    input  logic               in_nonzero,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic               mul_done,
    output mm3_pkg::mm3_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_POST  = 3'd3;
    localparam logic [2:0] S_FIN0  = 3'd4;
    localparam logic [2:0] S_FIN1  = 3'd5;
    localparam logic [2:0] S_FX    = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       last_reg, last_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = op_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    last_next = in_last;
                    if (!in_last || in_nonzero)
                    begin
                        op_next    = mm3_pkg::OP_A_C1;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        state_next = S_FIN0;
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    cmd.mul_wb = 1'b1;
                    if (op_reg == mm3_pkg::OP_B_C1)
                    begin
                        state_next = S_POST;
                    end
                    else if (op_reg == mm3_pkg::OP_H2_M2)
                    begin
                        state_next = S_FX;
                    end
                    else
                    begin
                        op_next    = op_reg + 3'd1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_POST:
            begin
                cmd.post   = 1'b1;
                state_next = last_reg ? S_FIN0 : S_IDLE;
            end
            S_FIN0:
            begin
                cmd.fin0   = 1'b1;
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                cmd.fin1   = 1'b1;
                op_next    = mm3_pkg::OP_H1_M1;
                state_next = S_ISSUE;
            end
            S_FX:
            begin
                cmd.fx     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fout       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= mm3_pkg::OP_A_C1;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- src/murmur3_128bit_stream_hash.sv -----
// ============================================================================
// murmur3_128bit_stream_hash
// Streaming 128-bit block hash with evolving multipliers, one message of
// 16-byte blocks at a time, finalized with the total length on the last block.
//
//   Channel    Direction  Transaction
//   blk_in     sink       one 16-byte block with byte count and last mark
//   hash_out   source     one 128-bit hash per message
//   cfg        write      32-bit seed, write enable and data
//
// A mixed block takes four 64-bit multiplies, each three steps of the single
// shared 32x32 multiplier plus issue and write-back, and then the state update.
// A last block adds four more multiplies, the two final mixing rounds of each
// half; with a zero byte count only those four run. Reset clears the state to
// the zero seed at once. The finished hash waits in an output register, so
// the next block is taken while the result is still unclaimed.
// ============================================================================
module murmur3_128bit_stream_hash #(
    parameter int LENGTH_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    mm3_blk_if.sink           blk_in,
    mm3_hash_if.source        hash_out,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata
);

    mm3_pkg::mm3_cmd_t cmd;
    logic              mul_done;

    mm3_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (blk_in.valid),
        .in_last    (blk_in.last_block),
        .in_nonzero (blk_in.valid_bytes != 5'd0),
        .in_ready   (blk_in.ready),
        .out_valid  (hash_out.valid),
        .out_ready  (hash_out.ready),
        .mul_done   (mul_done),
        .cmd        (cmd)
    );

    mm3_datapath #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mul_done    (mul_done),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .word_low    (blk_in.word_low),
        .word_high   (blk_in.word_high),
        .valid_bytes (blk_in.valid_bytes),
        .last_block  (blk_in.last_block),
        .hash_lo     (hash_out.hash_lo),
        .hash_hi     (hash_out.hash_hi)
    );

`ifndef NO_ASSERTIONS
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_start, cmd.mul_wb, cmd.post,
                  cmd.fin0, cmd.fin1, cmd.fx, cmd.fout}))
        else $error("More than one datapath command in a cycle.");

    a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> $past(cmd.mul_start, 4))
        else $error("Multiplier finished without a start four cycles earlier.");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |=> !blk_in.ready && !cmd.mul_start)
        else $error("Block taken or multiply restarted while a multiply runs.");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fout |=> hash_out.valid)
        else $error("Finished hash not presented on the output.");
`endif

endmodule
